@@ src/kci_pkg.sv @@
package kci_pkg;

	// Datapath widths
	localparam int TIMER_BITS = 24;
	localparam int PULSE_BITS = 20;
	localparam int CFG_BITS   = 24;
	localparam int CFG_IDX_BITS = 2;

	localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

	// Configuration reset values
	localparam logic [CFG_BITS-1:0] MIN_CHARGE_RST  = CFG_BITS'(2000000);
	localparam logic [CFG_BITS-1:0] COOLDOWN_RST    = CFG_BITS'(2000000);
	localparam logic [CFG_BITS-1:0] DISCHARGE_RST   = CFG_BITS'(500000);
	localparam logic [CFG_BITS-1:0] RECHARGE_GAP_RST = CFG_BITS'(10);

	// Configuration register indexes
	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_MIN_CHARGE   = 2'd0,
		CFG_COOLDOWN     = 2'd1,
		CFG_DISCHARGE    = 2'd2,
		CFG_RECHARGE_GAP = 2'd3
	} cfg_idx_t;

	// Input item kinds
	typedef enum logic [1:0] {
		MODE_TICK       = 2'd0,
		MODE_CHARGE_ON  = 2'd1,
		MODE_CHARGE_OFF = 2'd2,
		MODE_KICK       = 2'd3
	} mode_t;

	// Result status codes
	typedef enum logic [2:0] {
		ST_NONE       = 3'd0,
		ST_KICK_OK    = 3'd1,
		ST_CHARGE_OFF = 3'd2,
		ST_TOO_SHORT  = 3'd3,
		ST_COOLDOWN   = 3'd4,
		ST_ZERO_PULSE = 3'd5,
		ST_BUSY       = 3'd6
	} status_t;

	// Kick sequence phases
	typedef enum logic [3:0] {
		PH_IDLE  = 4'b0001,
		PH_WAIT  = 4'b0010,
		PH_PULSE = 4'b0100,
		PH_GAP   = 4'b1000
	} phase_t;

	// Saturating increment of a microsecond counter
	function automatic logic [TIMER_BITS-1:0] sat_inc(input logic [TIMER_BITS-1:0] v);
		logic [TIMER_BITS-1:0] r;
		if (v == TIMER_MAX) begin
			r = TIMER_MAX;
		end else begin
			r = v + TIMER_BITS'(1);
		end
		return r;
	endfunction

endpackage

@@ src/kicker_charge_interlock.sv @@
// Kicker charge interlock and pulse sequencer.
// Input channel (in_valid/in_ready, mode, pulse_len): one item per transfer,
// either a one-microsecond tick or a command (charge on, charge off, kick).
// Output channel (out_valid/out_ready): exactly one result per input item,
// carrying kick_drive, charge_drive, status and busy_res after that item.
// Configuration: cfg_we/cfg_addr/cfg_data write the four timing registers,
// one per write; write them only while no item is in flight.
// Latency: the result of an item is valid the cycle after its transfer.
// Throughput: one item per cycle while out_ready is high; the whole interlock
// check and phase sequencing is one pass of compare logic between the state
// registers and the result register.
// Stall: in_ready stays high while the result register is empty or being
// taken; when the receiver holds out_ready low with a result pending, the
// input stalls and the result holds.
// Reset: charging on, charge timer zero, cooldown timer saturated (kick
// allowed once charged), sequencer idle, registers at their defaults.
module kicker_charge_interlock (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    mode,
	input  logic [kci_pkg::PULSE_BITS-1:0] pulse_len,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          kick_drive,
	output logic                          charge_drive,
	output logic [2:0]                    status,
	output logic                          busy_res,
	input  logic                          cfg_we,
	input  logic [kci_pkg::CFG_IDX_BITS-1:0] cfg_addr,
	input  logic [kci_pkg::CFG_BITS-1:0]  cfg_data
);
	import kci_pkg::*;

	localparam int PAD_BITS = TIMER_BITS - PULSE_BITS;

	// Configuration registers
	logic [CFG_BITS-1:0] min_charge_q, cooldown_q, discharge_q, gap_q;

	// Interlock state
	logic                  charging_q;
	logic [TIMER_BITS-1:0] charge_el_q, since_kick_q, phase_cnt_q;
	logic [PULSE_BITS-1:0] pulse_q;
	phase_t                phase_q;

	// Result register
	logic    out_valid_q;
	logic    kick_q, charge_q, busy_q;
	status_t status_q;

	// Next-state values
	logic                  chg_n;
	logic [TIMER_BITS-1:0] el_n, since_n, cnt_n;
	logic [PULSE_BITS-1:0] pulse_n;
	phase_t                ph_n;
	status_t               st_n;

	logic in_xfer;

	assign in_ready = !out_valid_q || out_ready;
	assign in_xfer  = in_valid && in_ready;

	// Length of a phase, in microseconds
	function automatic logic [TIMER_BITS-1:0] phase_len(
		input phase_t ph,
		input logic [CFG_BITS-1:0] dis,
		input logic [CFG_BITS-1:0] gap,
		input logic [PULSE_BITS-1:0] pls
	);
		logic [TIMER_BITS-1:0] r;
		unique case (ph)
			PH_WAIT:  r = dis;
			PH_PULSE: r = {{PAD_BITS{1'b0}}, pls};
			default:  r = gap;
		endcase
		return r;
	endfunction

	// Interlock checks and phase sequencing
	always_comb begin
		logic stop;
		chg_n   = charging_q;
		el_n    = charge_el_q;
		since_n = since_kick_q;
		cnt_n   = phase_cnt_q;
		pulse_n = pulse_q;
		ph_n    = phase_q;
		st_n    = ST_NONE;
		stop    = 1'b1;

		priority if (mode == MODE_TICK) begin
			if (charging_q) el_n = sat_inc(charge_el_q);
			since_n = sat_inc(since_kick_q);
			if (phase_q != PH_IDLE) begin
				cnt_n = sat_inc(phase_cnt_q);
				stop  = 1'b0;
			end
		end else if (phase_q != PH_IDLE) begin
			st_n = ST_BUSY;
		end else if (mode == MODE_CHARGE_ON) begin
			if (!charging_q) begin
				chg_n = 1'b1;
				el_n  = '0;
			end
		end else if (mode == MODE_CHARGE_OFF) begin
			chg_n = 1'b0;
		end else begin
			priority if (pulse_len == '0) begin
				st_n = ST_ZERO_PULSE;
			end else if (!charging_q) begin
				st_n = ST_CHARGE_OFF;
			end else if (charge_el_q < min_charge_q) begin
				st_n = ST_TOO_SHORT;
			end else if (since_kick_q < cooldown_q) begin
				st_n = ST_COOLDOWN;
			end else begin
				st_n    = ST_KICK_OK;
				chg_n   = 1'b0;
				pulse_n = pulse_len;
				ph_n    = PH_WAIT;
				cnt_n   = '0;
				stop    = 1'b0;
			end
		end

		// Pass through every phase that has ended, zero-length ones included
		for (int n = 0; n < 4; n++) begin
			if (!stop && ph_n != PH_IDLE) begin
				if (cnt_n < phase_len(ph_n, discharge_q, gap_q, pulse_n) &&
				    cnt_n != TIMER_MAX) begin
					stop = 1'b1;
				end else begin
					cnt_n = '0;
					unique case (ph_n)
						PH_WAIT:  ph_n = PH_PULSE;
						PH_PULSE: ph_n = PH_GAP;
						default: begin
							ph_n    = PH_IDLE;
							since_n = '0;
							chg_n   = 1'b1;
							el_n    = '0;
						end
					endcase
				end
			end
		end
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_charge_q <= MIN_CHARGE_RST;
			cooldown_q   <= COOLDOWN_RST;
			discharge_q  <= DISCHARGE_RST;
			gap_q        <= RECHARGE_GAP_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_addr))
				CFG_MIN_CHARGE:   min_charge_q <= cfg_data;
				CFG_COOLDOWN:     cooldown_q   <= cfg_data;
				CFG_DISCHARGE:    discharge_q  <= cfg_data;
				CFG_RECHARGE_GAP: gap_q        <= cfg_data;
				default: ;
			endcase
		end
	end

	// State update on input transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			charging_q   <= 1'b1;
			charge_el_q  <= '0;
			since_kick_q <= TIMER_MAX;
			phase_cnt_q  <= '0;
			pulse_q      <= '0;
			phase_q      <= PH_IDLE;
		end else if (in_xfer) begin
			charging_q   <= chg_n;
			charge_el_q  <= el_n;
			since_kick_q <= since_n;
			phase_cnt_q  <= cnt_n;
			pulse_q      <= pulse_n;
			phase_q      <= ph_n;
		end
	end

	// Result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_xfer) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			kick_q   <= (ph_n == PH_PULSE);
			charge_q <= chg_n;
			status_q <= st_n;
			busy_q   <= (ph_n != PH_IDLE);
		end
	end

	assign out_valid    = out_valid_q;
	assign kick_drive   = kick_q;
	assign charge_drive = charge_q;
	assign status       = status_q;
	assign busy_res     = busy_q;

endmodule
